@@ rtl/mws_pkg.sv @@
package mws_pkg;

	// default fraction bits of the rounded sine and cosine
	localparam int TRIG_BITS_DEF = 16;

	// Horner series, six terms each
	localparam int N_TERMS = 6;
	localparam int SIN_DIV [N_TERMS] = '{156, 110, 72, 42, 20, 6};
	localparam int COS_DIV [N_TERMS] = '{182, 132, 90, 56, 30, 12};

	localparam logic [30:0] Q30_ONE = 31'h4000_0000;
	localparam logic [31:0] PI_Q30  = 32'd3373259426;

	// internal value widths
	localparam int VEL_W = 18;  // rotated velocity, mm/s
	localparam int SUM_W = 34;  // wheel surface speed, 0.001 mm/s
	localparam int MAG_W = 32;  // magnitude of a wheel sum

	// cycles from an accepted word to its result strobe
	localparam int LATENCY = 23;

	// configuration
	localparam int          CFG_IDX_W = 1;
	localparam logic [15:0] SPAN_RST  = 16'd400;
	localparam logic [31:0] GAIN_RST  = 32'd8237;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SPAN = 1'b0,
		CFG_GAIN = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		MODE_STOP  = 2'd0,
		MODE_ROBOT = 2'd1,
		MODE_WORLD = 2'd2,
		MODE_RSVD  = 2'd3
	} mode_t;

endpackage

@@ rtl/mecanum_wheel_speed_mixer.sv @@
// Mecanum wheel speed mixer: planar velocity, turn rate and heading in,
// four saturated wheel speeds in rpm out.
// Command channel: a word is taken at each rising edge with start high and
// busy low. busy never rises, so a new word may enter every cycle.
// Result channel: done is high for one cycle with the four rpm values;
// the receiver cannot stall and must take the word in that cycle.
// Throughput is one word per cycle. Depth is set by the two
// six-cell Horner chains (two stages per cell) that form sine and cosine.
// Configuration: cfg_valid / cfg_ready / cfg_index / cfg_data. cfg_ready is
// always high; index 0 is wheel span in mm, index 1 the Q16.16 rpm gain.
// Write configuration only while no word is in flight.
// Reset (arst_n low) empties the pipeline, drops done and loads the
// register defaults: span 400 mm, gain 8237.
module mecanum_wheel_speed_mixer #(
	parameter int TRIG_BITS = mws_pkg::TRIG_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [1:0]                      mode,
	input  logic signed [15:0]              vel_x,
	input  logic signed [15:0]              vel_y,
	input  logic signed [15:0]              turn_rate,
	input  logic [15:0]                     heading,
	output logic                            done,
	output logic signed [15:0]              rpm_front_left,
	output logic signed [15:0]              rpm_front_right,
	output logic signed [15:0]              rpm_back_right,
	output logic signed [15:0]              rpm_back_left,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [mws_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [31:0]                     cfg_data
);
	import mws_pkg::*;

	localparam int SH_T   = 30 - TRIG_BITS;      // Q30 to Q(TRIG_BITS)
	localparam int TW     = TRIG_BITS + 2;       // signed sin / cos width
	localparam int PW     = 16 + TW;             // velocity times trig
	localparam int RW     = PW + 1;              // rotation sum
	localparam int DEPTH  = 16;                  // side delay, stages s4..s19
	localparam logic [31:0]   HALF_Q = 32'd1 << (SH_T - 1);
	localparam logic [RW-1:0] HALF_V = RW'(1) << (TRIG_BITS - 1);

	typedef struct packed {
		mode_t              mode;
		logic signed [15:0] vx;
		logic signed [15:0] vy;
		logic [1:0]         quad;
		logic [30:0]        x;
		logic [31:0]        x2;
		logic signed [31:0] ws;
	} side_t;

	// configuration registers
	logic [15:0] span_q;
	logic [31:0] gain_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_q <= SPAN_RST;
			gain_q <= GAIN_RST;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SPAN: span_q <= cfg_data[15:0];
				CFG_GAIN: gain_q <= cfg_data;
			endcase
		end
	end

	// valid pipe, one bit per stage
	logic [LATENCY-1:0] vld_q;
	logic               accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LATENCY-2:0], accept};
		end
	end

	assign done = vld_q[LATENCY-1];

	// s1: capture
	mode_t              mode_s1;
	logic signed [15:0] vx_s1, vy_s1, w_s1;
	logic [15:0]        hd_s1;

	always_ff @(posedge clk) begin
		mode_s1 <= mode_t'(mode);
		vx_s1   <= vel_x;
		vy_s1   <= vel_y;
		w_s1    <= turn_rate;
		hd_s1   <= heading;
	end

	// s2: offset angle in Q30 radians, turn term
	mode_t              mode_s2;
	logic signed [15:0] vx_s2, vy_s2;
	logic [1:0]         quad_s2;
	logic [30:0]        x_s2;
	logic signed [31:0] ws_s2;
	logic [45:0]        x_full;

	assign x_full = {32'd0, hd_s1[13:0]} * {14'd0, PI_Q30};

	always_ff @(posedge clk) begin
		mode_s2 <= mode_s1;
		vx_s2   <= vx_s1;
		vy_s2   <= vy_s1;
		quad_s2 <= hd_s1[15:14];
		x_s2    <= x_full[45:15];
		ws_s2   <= 32'(w_s1 * $signed({1'b0, span_q}));
	end

	// s3: square of the angle
	side_t       side_s3;
	logic [61:0] xsq;

	assign xsq = 62'({31'd0, x_s2} * {31'd0, x_s2});

	always_ff @(posedge clk) begin
		side_s3.mode <= mode_s2;
		side_s3.vx   <= vx_s2;
		side_s3.vy   <= vy_s2;
		side_s3.quad <= quad_s2;
		side_s3.x    <= x_s2;
		side_s3.x2   <= xsq[61:30];
		side_s3.ws   <= ws_s2;
	end

	// s4..s15: Horner chains, one cell per term
	logic [31:0] sin_x2 [0:N_TERMS];
	logic [30:0] sin_t  [0:N_TERMS];
	logic [31:0] cos_x2 [0:N_TERMS];
	logic [30:0] cos_t  [0:N_TERMS];

	assign sin_x2[0] = side_s3.x2;
	assign sin_t[0]  = Q30_ONE;
	assign cos_x2[0] = side_s3.x2;
	assign cos_t[0]  = Q30_ONE;

	for (genvar i = 0; i < N_TERMS; i++) begin : g_terms
		mws_horner_cell #(.DIV(SIN_DIV[i])) u_sin (
			.clk    (clk),
			.x2_in  (sin_x2[i]),
			.t_in   (sin_t[i]),
			.x2_out (sin_x2[i+1]),
			.t_out  (sin_t[i+1])
		);
		mws_horner_cell #(.DIV(COS_DIV[i])) u_cos (
			.clk    (clk),
			.x2_in  (cos_x2[i]),
			.t_in   (cos_t[i]),
			.x2_out (cos_x2[i+1]),
			.t_out  (cos_t[i+1])
		);
	end

	// side data rides alongside, index k is stage s4+k
	side_t dl_q [0:DEPTH-1];

	always_ff @(posedge clk) begin
		dl_q[0] <= side_s3;
		for (int k = 1; k < DEPTH; k++) begin
			dl_q[k] <= dl_q[k-1];
		end
	end

	// s16: final sine product, cosine half term with clamp at zero
	logic [30:0] sv_s16, cv_s16;
	logic [61:0] sp;
	logic [62:0] cp;
	logic [31:0] cp_half;

	assign sp      = {31'd0, dl_q[11].x} * {31'd0, sin_t[N_TERMS]};
	assign cp      = {31'd0, dl_q[11].x2} * {32'd0, cos_t[N_TERMS]};
	assign cp_half = cp[62:31];

	always_ff @(posedge clk) begin
		sv_s16 <= sp[60:30];
		cv_s16 <= (cp_half > {1'b0, Q30_ONE}) ? 31'd0 : (Q30_ONE - cp_half[30:0]);
	end

	// s17: round to Q(TRIG_BITS), fold in quadrant
	logic signed [TW-1:0] s_s17, c_s17;
	logic [31:0]          sv_rnd, cv_rnd;
	logic signed [TW-1:0] sr, cr;

	assign sv_rnd = {1'b0, sv_s16} + HALF_Q;
	assign cv_rnd = {1'b0, cv_s16} + HALF_Q;
	assign sr     = $signed({1'b0, sv_rnd[SH_T+TRIG_BITS:SH_T]});
	assign cr     = $signed({1'b0, cv_rnd[SH_T+TRIG_BITS:SH_T]});

	always_ff @(posedge clk) begin
		unique case (dl_q[12].quad)
			2'd0: begin s_s17 <= sr;  c_s17 <= cr;  end
			2'd1: begin s_s17 <= cr;  c_s17 <= -sr; end
			2'd2: begin s_s17 <= -sr; c_s17 <= -cr; end
			2'd3: begin s_s17 <= -cr; c_s17 <= sr;  end
		endcase
	end

	// s18: rotation products
	logic signed [PW-1:0] xc_s18, ys_s18, yc_s18, xs_s18;

	always_ff @(posedge clk) begin
		xc_s18 <= PW'(dl_q[13].vx * c_s17);
		ys_s18 <= PW'(dl_q[13].vy * s_s17);
		yc_s18 <= PW'(dl_q[13].vy * c_s17);
		xs_s18 <= PW'(dl_q[13].vx * s_s17);
	end

	// s19: round rotation, select by mode
	logic signed [RW-1:0]    rx, ry, rxh, ryh;
	logic signed [RW-1:0]    rxs, rys;
	logic signed [VEL_W-1:0] vx_s19, vy_s19;

	assign rx  = RW'(xc_s18) + RW'(ys_s18);
	assign ry  = RW'(yc_s18) - RW'(xs_s18);
	assign rxh = rx + $signed(HALF_V);
	assign ryh = ry + $signed(HALF_V);
	assign rxs = rxh >>> TRIG_BITS;
	assign rys = ryh >>> TRIG_BITS;

	always_ff @(posedge clk) begin
		unique case (dl_q[14].mode)
			MODE_WORLD: begin
				vx_s19 <= rxs[VEL_W-1:0];
				vy_s19 <= rys[VEL_W-1:0];
			end
			MODE_ROBOT: begin
				vx_s19 <= VEL_W'(dl_q[14].vx);
				vy_s19 <= VEL_W'(dl_q[14].vy);
			end
			// stop and the unused code keep only the turn term
			MODE_STOP, MODE_RSVD: begin
				vx_s19 <= '0;
				vy_s19 <= '0;
			end
		endcase
	end

	// s20: wheel surface speeds in 0.001 mm/s
	logic signed [SUM_W-1:0] fl_s20, fr_s20, br_s20, bl_s20;
	logic signed [SUM_W-1:0] vxw, vyw, wsw;

	assign vxw = SUM_W'(vx_s19);
	assign vyw = SUM_W'(vy_s19);
	assign wsw = SUM_W'(dl_q[15].ws);

	always_ff @(posedge clk) begin
		fl_s20 <= SUM_W'((vyw - vxw) * 34'sd1000) + wsw;
		fr_s20 <= SUM_W'((-vxw - vyw) * 34'sd1000) + wsw;
		br_s20 <= SUM_W'((vxw - vyw) * 34'sd1000) + wsw;
		bl_s20 <= SUM_W'((vxw + vyw) * 34'sd1000) + wsw;
	end

	// s21..s23: gain, divide, saturate per wheel
	mws_wheel_out u_fl (.clk(clk), .sum(fl_s20), .gain(gain_q), .rpm(rpm_front_left));
	mws_wheel_out u_fr (.clk(clk), .sum(fr_s20), .gain(gain_q), .rpm(rpm_front_right));
	mws_wheel_out u_br (.clk(clk), .sum(br_s20), .gain(gain_q), .rpm(rpm_back_right));
	mws_wheel_out u_bl (.clk(clk), .sum(bl_s20), .gain(gain_q), .rpm(rpm_back_left));

endmodule

@@ rtl/mws_horner_cell.sv @@
module mws_horner_cell #(
	parameter int DIV = 6
) (
	input  logic        clk,
	input  logic [31:0] x2_in,
	input  logic [30:0] t_in,
	output logic [31:0] x2_out,
	output logic [30:0] t_out
);
	import mws_pkg::*;

	// exact floor(p / DIV) for any 32-bit p
	localparam int          SH    = 32 + $clog2(DIV);
	localparam logic [32:0] RECIP = 33'(((65'd1 << SH) + 65'(DIV) - 65'd1) / 65'(DIV));

	logic [61:0] prod_s1;
	logic [31:0] x2_s1;
	logic [31:0] x2_s2;
	logic [30:0] t_s2;
	logic [31:0] p;
	logic [64:0] q_full;
	logic [30:0] quo;

	always_ff @(posedge clk) begin
		prod_s1 <= 62'({31'd0, x2_in} * {32'd0, t_in});
		x2_s1   <= x2_in;
	end

	assign p      = prod_s1[61:30];
	assign q_full = {33'd0, p} * {32'd0, RECIP};
	assign quo    = 31'(q_full >> SH);

	always_ff @(posedge clk) begin
		t_s2  <= Q30_ONE - quo;
		x2_s2 <= x2_s1;
	end

	assign x2_out = x2_s2;
	assign t_out  = t_s2;

endmodule

@@ rtl/mws_wheel_out.sv @@
module mws_wheel_out (
	input  logic                          clk,
	input  logic signed [mws_pkg::SUM_W-1:0] sum,
	input  logic [31:0]                   gain,
	output logic signed [15:0]            rpm
);
	import mws_pkg::*;

	localparam int          Q_DIV    = 1000;
	localparam logic [64:0] HALF_DIV = 65'd32768000;  // 65536000 / 2
	localparam logic [48:0] SAT_LIM  = 49'd32768000;  // 32768 * 1000
	localparam int          R_SH     = 35;
	localparam logic [25:0] RECIP    = 26'(((64'd1 << R_SH) + 64'(Q_DIV) - 64'd1) / 64'(Q_DIV));

	logic             neg_s21, neg_s22;
	logic [63:0]      prod_s21;
	logic [MAG_W-1:0] mag;
	logic [SUM_W-1:0] abs_sum;
	logic [64:0]      n;
	logic [48:0]      m;
	logic             sat_s22;
	logic [24:0]      m_s22;
	logic [50:0]      q_full;
	logic [14:0]      q;
	logic signed [15:0] rpm_s23;

	assign abs_sum = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
	assign mag     = abs_sum[MAG_W-1:0];

	always_ff @(posedge clk) begin
		neg_s21  <= sum[SUM_W-1];
		prod_s21 <= {32'd0, mag} * {32'd0, gain};
	end

	// divide by 65536000: drop 16 bits, then divide by 1000
	assign n = {1'b0, prod_s21} + HALF_DIV;
	assign m = n[64:16];

	always_ff @(posedge clk) begin
		neg_s22 <= neg_s21;
		sat_s22 <= (m >= SAT_LIM);
		m_s22   <= m[24:0];
	end

	assign q_full = {26'd0, m_s22} * {25'd0, RECIP};
	assign q      = 15'(q_full >> R_SH);

	always_ff @(posedge clk) begin
		if (sat_s22) begin
			rpm_s23 <= neg_s22 ? 16'sh8000 : 16'sh7FFF;
		end else begin
			rpm_s23 <= neg_s22 ? -$signed({1'b0, q}) : $signed({1'b0, q});
		end
	end

	assign rpm = rpm_s23;

endmodule

@@ rtl/mws_checker.sv @@
module mws_props (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic [1:0]                    mode,
	input logic signed [15:0]            turn_rate,
	input logic                          done,
	input logic signed [15:0]            rpm_front_left,
	input logic signed [15:0]            rpm_front_right,
	input logic signed [15:0]            rpm_back_right,
	input logic signed [15:0]            rpm_back_left
);
	import mws_pkg::*;

	// every result traces back to an accepted command word
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without matching command word");

	// every accepted word gives a result
	a_done_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("command word lost");

	// stop and reserved mode: pure rotation, all four wheels alike
	a_stop_eq: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (mode == MODE_STOP || mode == MODE_RSVD)) |-> ##LATENCY
		(rpm_front_left == rpm_front_right && rpm_front_left == rpm_back_right &&
		 rpm_front_left == rpm_back_left))
		else $error("stop mode wheels differ");

	// stop with no turn: front left wheel at rest
	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && mode == MODE_STOP && turn_rate == 16'sd0) |-> ##LATENCY
		(rpm_front_left == 16'sd0))
		else $error("stop mode with zero turn gives motion");

endmodule

bind mecanum_wheel_speed_mixer mws_props u_mws_props (.*);
